// ===== design/rle_pixel_row_decoder_core_macros.svh =====
// Assertion macros for the row decoder core.
`ifndef RLE_PIXEL_ROW_DECODER_CORE_MACROS_SVH
`define RLE_PIXEL_ROW_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is held
`define RPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is held
`define RPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rpd_pkg.sv =====
// Shared types and constants for the run-length row decoder.
package rpd_pkg;

  localparam int ROW_W  = 10;
  localparam int COL_W  = 10;
  localparam int CUR_W  = 11;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 8;

  localparam int FRAME_DIM_DEF = 1024;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  // Header decode: bit 7 = literal, count byte-0x7F; else count byte+1
  localparam int               HDR_LIT_BIT  = 7;
  localparam logic [BYTE_W-1:0] HDR_LIT_BIAS = 8'h7F;

  // Classified item handed from front to back
  typedef struct packed {
    logic              is_start;
    logic              start_ok;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  first_col;
    logic [COL_W-1:0]  end_col;
    logic              raw;
    logic [BYTE_W-1:0] data;
    logic              hdr_lit;
    logic [LEN_W-1:0]  hdr_count;
  } cmd_t;

endpackage

// ===== design/rpd_front.sv =====
// Front end: holds the mode register and classifies each incoming item.
module rpd_front #(
  parameter int FRAME_DIM = rpd_pkg::FRAME_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_func,
  input  logic [rpd_pkg::ROW_W-1:0]  in_row,
  input  logic [rpd_pkg::COL_W-1:0]  in_first_col,
  input  logic [rpd_pkg::COL_W-1:0]  in_last_col,
  input  logic [rpd_pkg::BYTE_W-1:0] in_data_byte,
  output rpd_pkg::cmd_t              cmd
);

  localparam int FrameLast = FRAME_DIM - 1;

  logic                      raw_mode_r;
  logic                      raw_mode_nxt;
  logic [rpd_pkg::COL_W-1:0] last_clip;

  // Mode register
  always_comb begin
    raw_mode_nxt = raw_mode_r;
    if (cfg_wr_en) begin
      raw_mode_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
    end else begin
      raw_mode_r <= raw_mode_nxt;
    end
  end

  // Clip last column to the frame
  always_comb begin
    if (int'(in_last_col) > FrameLast) begin
      last_clip = rpd_pkg::COL_W'(FrameLast);
    end else begin
      last_clip = in_last_col;
    end
  end

  // Classify: start check and header decode are done up front
  always_comb begin
    cmd.is_start  = (in_func == rpd_pkg::FUNC_START);
    cmd.start_ok  = (int'(in_row) < FRAME_DIM) && (in_first_col <= last_clip);
    cmd.row       = in_row;
    cmd.first_col = in_first_col;
    cmd.end_col   = last_clip;
    cmd.raw       = raw_mode_r;
    cmd.data      = in_data_byte;
    cmd.hdr_lit   = in_data_byte[rpd_pkg::HDR_LIT_BIT];
    if (cmd.hdr_lit) begin
      cmd.hdr_count = in_data_byte - rpd_pkg::HDR_LIT_BIAS;
    end else begin
      cmd.hdr_count = in_data_byte + 8'd1;
    end
  end

endmodule

// ===== design/rpd_queue.sv =====
// Two-entry command queue between front and back.
module rpd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output rpd_pkg::cmd_t head_cmd
);

  rpd_pkg::cmd_t                entry_r [rpd_pkg::QUEUE_DEPTH];
  logic [rpd_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rpd_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rpd_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == rpd_pkg::QCNT_W'(rpd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/rpd_back.sv =====
// Back end: row state, run-length sequencing and the registered result.
module rpd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  rpd_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [rpd_pkg::ROW_W-1:0]  out_pix_row,
  output logic [rpd_pkg::COL_W-1:0]  out_pix_col,
  output logic [rpd_pkg::LEN_W-1:0]  out_span_len,
  output logic [rpd_pkg::BYTE_W-1:0] out_pix_value,
  output logic                       out_row_done
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  logic                       active_r, active_nxt;
  logic [rpd_pkg::CUR_W-1:0]  cur_col_r, cur_col_nxt;
  logic [rpd_pkg::COL_W-1:0]  end_col_r, end_col_nxt;
  logic [rpd_pkg::ROW_W-1:0]  cur_row_r, cur_row_nxt;
  phase_t                     phase_r, phase_nxt;
  logic [rpd_pkg::LEN_W-1:0]  run_left_r, run_left_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [rpd_pkg::ROW_W-1:0]  out_row_r;
  logic [rpd_pkg::COL_W-1:0]  out_col_r;
  logic [rpd_pkg::LEN_W-1:0]  out_len_r;
  logic [rpd_pkg::BYTE_W-1:0] out_value_r;
  logic                       out_done_r;

  logic                       emit;
  logic                       done;
  logic [rpd_pkg::LEN_W-1:0]  emit_len;
  logic [rpd_pkg::LEN_W-1:0]  run_dec;
  logic [rpd_pkg::CUR_W-1:0]  room;
  logic [rpd_pkg::CUR_W-1:0]  rep_min;
  logic [rpd_pkg::LEN_W-1:0]  rep_len;
  logic [rpd_pkg::CUR_W:0]    col_sum;

  // Next item is taken whenever the result register is free or draining
  assign cmd_pop = cmd_valid && (!out_valid_r || !out_stall);

  // Repeat span clipped to the room left in the row
  always_comb begin
    run_dec = run_left_r - 8'd1;
    room    = {1'b0, end_col_r} - cur_col_r + 11'd1;
    if ({3'b000, run_left_r} > room) begin
      rep_min = room;
    end else begin
      rep_min = {3'b000, run_left_r};
    end
    if (rep_min == '0) begin
      rep_len = 8'd1;
    end else begin
      rep_len = rep_min[rpd_pkg::LEN_W-1:0];
    end
  end

  // Execute one classified item
  always_comb begin
    active_nxt   = active_r;
    cur_col_nxt  = cur_col_r;
    end_col_nxt  = end_col_r;
    cur_row_nxt  = cur_row_r;
    phase_nxt    = phase_r;
    run_left_nxt = run_left_r;
    emit         = 1'b0;
    emit_len     = 8'd1;
    done         = 1'b0;
    col_sum      = '0;

    if (cmd_pop) begin
      if (cmd.is_start) begin
        cur_row_nxt  = cmd.row;
        cur_col_nxt  = {1'b0, cmd.first_col};
        end_col_nxt  = cmd.end_col;
        phase_nxt    = PH_HEADER;
        run_left_nxt = '0;
        active_nxt   = cmd.start_ok;
      end else if (active_r) begin
        if (cmd.raw) begin
          emit = 1'b1;
        end else begin
          case (phase_r)
            PH_LITERAL: begin
              run_left_nxt = run_dec;
              if (run_dec == '0) begin
                phase_nxt = PH_HEADER;
              end
              emit = 1'b1;
            end
            PH_REPEAT: begin
              emit_len     = rep_len;
              phase_nxt    = PH_HEADER;
              run_left_nxt = '0;
              emit         = 1'b1;
            end
            default: begin
              // header byte: no result, load the group count
              run_left_nxt = cmd.hdr_count;
              phase_nxt    = cmd.hdr_lit ? PH_LITERAL : PH_REPEAT;
            end
          endcase
        end

        // Advance the column and close the row at the last column
        if (emit) begin
          col_sum     = {1'b0, cur_col_r} + {4'b0000, emit_len};
          done        = (col_sum > {2'b00, end_col_r});
          cur_col_nxt = col_sum[rpd_pkg::CUR_W-1:0];
          if (done) begin
            active_nxt   = 1'b0;
            phase_nxt    = PH_HEADER;
            run_left_nxt = '0;
          end
        end
      end
    end
  end

  // Result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_pop) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cur_col_r   <= '0;
      end_col_r   <= '0;
      cur_row_r   <= '0;
      phase_r     <= PH_HEADER;
      run_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cur_col_r   <= cur_col_nxt;
      end_col_r   <= end_col_nxt;
      cur_row_r   <= cur_row_nxt;
      phase_r     <= phase_nxt;
      run_left_r  <= run_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r   <= cur_row_r;
      out_col_r   <= cur_col_r[rpd_pkg::COL_W-1:0];
      out_len_r   <= emit_len;
      out_value_r <= cmd.data;
      out_done_r  <= done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pix_row   = out_row_r;
  assign out_pix_col   = out_col_r;
  assign out_span_len  = out_len_r;
  assign out_pix_value = out_value_r;
  assign out_row_done  = out_done_r;

endmodule

// ===== design/rle_pixel_row_decoder_core.sv =====
// Path: an accepted data byte passes through the command queue and then the result register.
// Throughput: one item per cycle while the output is not stalled, set by the single-step
// back end; the two-entry command queue absorbs output stall.
// Reset: synchronous, active low; clears the queue, the row state, the
// result valid and the raw byte mode register. No clearing pass.
`include "rle_pixel_row_decoder_core_macros.svh"

module rle_pixel_row_decoder_core #(
  parameter int FRAME_DIM = rpd_pkg::FRAME_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [rpd_pkg::ROW_W-1:0]  in_row,
  input  logic [rpd_pkg::COL_W-1:0]  in_first_col,
  input  logic [rpd_pkg::COL_W-1:0]  in_last_col,
  input  logic [rpd_pkg::BYTE_W-1:0] in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rpd_pkg::ROW_W-1:0]  out_pix_row,
  output logic [rpd_pkg::COL_W-1:0]  out_pix_col,
  output logic [rpd_pkg::LEN_W-1:0]  out_span_len,
  output logic [rpd_pkg::BYTE_W-1:0] out_pix_value,
  output logic                       out_row_done
);

  rpd_pkg::cmd_t             front_cmd;
  rpd_pkg::cmd_t             head_cmd;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;
  logic                      in_xfer;
  logic [rpd_pkg::COL_W+1:0] span_end;
  logic                      span_ok;

  assign in_stall = q_full;
  assign in_xfer  = in_valid && !in_stall;

  // Classify
  rpd_front #(
    .FRAME_DIM (FRAME_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_func      (in_func),
    .in_row       (in_row),
    .in_first_col (in_first_col),
    .in_last_col  (in_last_col),
    .in_data_byte (in_data_byte),
    .cmd          (front_cmd)
  );

  // Decouple
  rpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_xfer),
    .push_cmd   (front_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // Execute
  rpd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd           (head_cmd),
    .cmd_pop       (q_pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_pix_row   (out_pix_row),
    .out_pix_col   (out_pix_col),
    .out_span_len  (out_span_len),
    .out_pix_value (out_pix_value),
    .out_row_done  (out_row_done)
  );

  // Span end for the row bound check
  assign span_end = {2'b00, out_pix_col} + {4'b0000, out_span_len};
  assign span_ok  = (span_end <= 12'd1024) && (out_span_len != '0);

  // Checks
  `RPD_ASSERT_IMP(a_full_has_head, in_stall, q_valid, "queue full but head not valid")
  `RPD_ASSERT_NEXT(a_xfer_queued, in_xfer, q_valid, "accepted item missing from queue")
  `RPD_ASSERT_IMP(a_span_in_row, out_valid, span_ok, "span runs past the row")

endmodule
